// File: sv/assert_macros.svh
// Concurrent assertion helpers; define NO_ASSERTIONS to drop them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define LFBP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication violated");
`define LFBP_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication violated");
`else
`define LFBP_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define LFBP_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

// File: sv/lfbp_pkg.sv
package lfbp_pkg;

    localparam int MAX_FIELD_BITS = 24;

    localparam logic [7:0] BYTE_FF    = 8'hFF;
    localparam logic [7:0] BYTE_STUFF = 8'h00;

    typedef enum logic
    {
        OPC_WRITE = 1'b0,
        OPC_FLUSH = 1'b1
    } opcode_t;

    typedef struct packed
    {
        logic [2:0][7:0] data;
        logic [1:0]      count;
    } burst_t;

endpackage

// File: sv/lfbp_in_if.sv
interface lfbp_in_if;
    logic        valid;
    logic        ready;
    logic        opcode;
    logic [23:0] field_value;
    logic [4:0]  bit_count;

    modport source (output valid, output opcode, output field_value, output bit_count,
                    input ready);
    modport sink (input valid, input opcode, input field_value, input bit_count,
                  output ready);
endinterface

// File: sv/lfbp_out_if.sv
interface lfbp_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last_of_item;

    modport source (output valid, output out_byte, output last_of_item, input ready);
    modport sink (input valid, input out_byte, input last_of_item, output ready);
endinterface

// File: sv/lfbp_pack.sv
module lfbp_pack
    import lfbp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        take,
    input  logic        opcode,
    input  logic [23:0] field_value,
    input  logic [4:0]  bit_count,
    output burst_t      burst
);

    logic [6:0]  pend_bits_reg;
    logic [6:0]  pend_bits_next;
    logic [2:0]  pend_cnt_reg;
    logic [2:0]  pend_cnt_next;
    logic [4:0]  n_sat;
    logic [23:0] mask;
    logic [30:0] win;
    logic [4:0]  total;
    logic [6:0]  rest;

    always_comb
    begin
        n_sat = (bit_count > 5'(MAX_FIELD_BITS)) ? 5'(MAX_FIELD_BITS) : bit_count;
        mask  = 24'((25'd1 << n_sat) - 25'd1);
        win   = {24'd0, pend_bits_reg} | ({7'd0, field_value & mask} << pend_cnt_reg);
        total = {2'b00, pend_cnt_reg} + n_sat;
        case (total[4:3])
            2'd0:    rest = win[6:0];
            2'd1:    rest = win[14:8];
            2'd2:    rest = win[22:16];
            default: rest = win[30:24];
        endcase

        if (opcode == OPC_FLUSH)
        begin
            burst.data     = {16'd0, 1'b0, pend_bits_reg};
            burst.count    = {1'b0, pend_cnt_reg != 3'd0};
            pend_bits_next = 7'd0;
            pend_cnt_next  = 3'd0;
        end
        else
        begin
            burst.data     = win[23:0];
            burst.count    = total[4:3];
            pend_bits_next = rest;
            pend_cnt_next  = total[2:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_bits_reg <= 7'd0;
            pend_cnt_reg  <= 3'd0;
        end
        else if (take)
        begin
            pend_bits_reg <= pend_bits_next;
            pend_cnt_reg  <= pend_cnt_next;
        end
    end

endmodule

// File: sv/lfbp_emit.sv
module lfbp_emit
    import lfbp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       escape_enable,
    input  logic       load_valid,
    input  burst_t     burst,
    output logic       load_ready,
    lfbp_out_if.source results
);

    logic [2:0][7:0] data_reg;
    logic [2:0][7:0] data_next;
    logic [1:0]      cnt_reg;
    logic [1:0]      cnt_next;
    logic            stuff_reg;
    logic            stuff_next;
    logic            out_valid_reg;
    logic [7:0]      out_byte_reg;
    logic            out_last_reg;
    logic            busy;
    logic            head_ff;
    logic [7:0]      head_byte;
    logic            head_last;
    logic            move;
    logic            load;

    always_comb
    begin
        busy       = (cnt_reg != 2'd0) || stuff_reg;
        head_ff    = escape_enable && (data_reg[0] == BYTE_FF);
        head_byte  = stuff_reg ? BYTE_STUFF : data_reg[0];
        head_last  = stuff_reg ? (cnt_reg == 2'd0) : ((cnt_reg == 2'd1) && !head_ff);
        move       = busy && (!out_valid_reg || results.ready);
        load_ready = !busy || (move && head_last);
        load       = load_valid && load_ready;

        data_next  = data_reg;
        cnt_next   = cnt_reg;
        stuff_next = stuff_reg;
        if (move)
        begin
            if (stuff_reg)
            begin
                stuff_next = 1'b0;
            end
            else
            begin
                data_next  = {8'd0, data_reg[2], data_reg[1]};
                cnt_next   = cnt_reg - 2'd1;
                stuff_next = head_ff;
            end
        end
        if (load)
        begin
            data_next  = burst.data;
            cnt_next   = burst.count;
            stuff_next = 1'b0;
        end
    end

    // hold the burst bytes
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
        if (move)
        begin
            out_byte_reg <= head_byte;
            out_last_reg <= head_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= 2'd0;
            stuff_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg   <= cnt_next;
            stuff_reg <= stuff_next;
            if (move)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (results.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign results.valid        = out_valid_reg;
    assign results.out_byte     = out_byte_reg;
    assign results.last_of_item = out_last_reg;

endmodule

// File: sv/lsb_first_bit_packer.sv
// An item's bytes are held in the burst register and sent out through the single-byte
// result register; one result byte per cycle while results.ready is not held low.
// A new item is accepted as the last result byte of the previous one moves on.
// Reset (async, active low) clears pending bits, the burst count and stuff flag
// (not the burst bytes) and result valid, and turns escape mode off.
`include "assert_macros.svh"

module lsb_first_bit_packer
    import lfbp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic       cfg_wdata,
    lfbp_in_if.sink    items,
    lfbp_out_if.source results
);

    logic   escape_enable_reg;
    logic   load_ready;
    logic   take;
    burst_t burst;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            escape_enable_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            escape_enable_reg <= cfg_wdata;
        end
    end

    assign take        = items.valid && load_ready;
    assign items.ready = load_ready;

    lfbp_pack u_pack
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .take        (take),
        .opcode      (items.opcode),
        .field_value (items.field_value),
        .bit_count   (items.bit_count),
        .burst       (burst)
    );

    lfbp_emit u_emit
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .escape_enable (escape_enable_reg),
        .load_valid    (items.valid),
        .burst         (burst),
        .load_ready    (load_ready),
        .results       (results)
    );

    `LFBP_ASSERT_IMP(a_ff_then_stuff, clk, rst_n, escape_enable_reg && results.valid && (results.out_byte == BYTE_FF), !results.last_of_item)
    `LFBP_ASSERT_NXT(a_stall_has_result, clk, rst_n, !items.ready, results.valid)

endmodule
